// ===== rtl/core/gpd_pkg.sv =====
// Shared types and constants of the pair grammar decompressor.
`timescale 1ns / 1ps

package gpd_pkg;

   localparam int SYM_W   = 11;
   localparam int RULE_AW = 10;
   localparam int BYTE_W  = 8;

   typedef enum logic [1:0] {
      FN_LOAD = 2'd0,
      FN_PUSH = 2'd1,
      FN_TICK = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_EMIT     = 3'd0,
      ST_IDLE     = 3'd1,
      ST_PUSH_OK  = 3'd2,
      ST_BUSY     = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_RULE,
      S_OUT
   } ctrl_state_type;

   typedef struct packed {
      func_type           func;
      logic [RULE_AW-1:0] rule_slot;
      logic [SYM_W-1:0]   left_symbol;
      logic [SYM_W-1:0]   right_symbol;
      logic [SYM_W-1:0]   compressed_symbol;
   } req_item_type;

   typedef struct packed {
      logic [SYM_W-1:0] left_symbol;
      logic [SYM_W-1:0] right_symbol;
   } rule_pair_type;

   typedef struct packed {
      logic               we;
      logic [RULE_AW-1:0] waddr;
      rule_pair_type      wdata;
      logic               re;
      logic [RULE_AW-1:0] raddr;
   } rule_req_type;

   typedef struct packed {
      status_type        status;
      logic [BYTE_W-1:0] out_byte;
      logic              run_done;
   } result_type;

endpackage

// ===== rtl/core/gpd_rule_mem.sv =====
// Rule table memory holding the left and right symbol of each rule.
`timescale 1ns / 1ps

module gpd_rule_mem #(
   parameter int DEPTH = 1024
) (
   input  logic                  clock,
   input  gpd_pkg::rule_req_type rule_req,
   output gpd_pkg::rule_pair_type rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   gpd_pkg::rule_pair_type mem [DEPTH];
   gpd_pkg::rule_pair_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (rule_req.we) begin
         mem[rule_req.waddr[AW-1:0]] <= rule_req.wdata;
      end
      if (rule_req.re) begin
         rd_data_ff <= mem[rule_req.raddr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gpd_stack_mem.sv =====
// Expansion stack memory with one write and one registered read port.
`timescale 1ns / 1ps

module gpd_stack_mem #(
   parameter int DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [$clog2(DEPTH)-1:0]    waddr,
   input  logic [gpd_pkg::SYM_W-1:0]   wdata,
   input  logic                        re,
   input  logic [$clog2(DEPTH)-1:0]    raddr,
   output logic [gpd_pkg::SYM_W-1:0]   rd_data
);

   logic [gpd_pkg::SYM_W-1:0] mem [DEPTH];
   logic [gpd_pkg::SYM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/gpd_ctrl.sv =====
// Sequencer that loads rules, pushes symbols and walks the stack to each terminal.
`timescale 1ns / 1ps

module gpd_ctrl #(
   parameter int MAX_RULES   = 1024,
   parameter int STACK_DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gpd_pkg::req_item_type               req_item,
   output gpd_pkg::rule_req_type               rule_req,
   input  gpd_pkg::rule_pair_type              rule_rd_data,
   output logic                                stk_we,
   output logic [$clog2(STACK_DEPTH)-1:0]      stk_waddr,
   output logic [gpd_pkg::SYM_W-1:0]           stk_wdata,
   output logic                                stk_re,
   output logic [$clog2(STACK_DEPTH)-1:0]      stk_raddr,
   input  logic [gpd_pkg::SYM_W-1:0]           stk_rd_data,
   output logic                                res_valid,
   output gpd_pkg::result_type                 res,
   input  logic                                out_free
);

   localparam int SA_W = $clog2(STACK_DEPTH);
   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam logic [SP_W-1:0] SP_OVF_LIM = SP_W'(STACK_DEPTH - 2);
   localparam int SYM_W = gpd_pkg::SYM_W;
   localparam int RULE_AW = gpd_pkg::RULE_AW;

   gpd_pkg::ctrl_state_type state_ff, state_in;
   logic [SP_W-1:0]         sp_ff, sp_in;
   gpd_pkg::result_type     res_ff, res_in;
   logic                    oor_ff, oor_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpd_pkg::S_IDLE;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
      end
      res_ff <= res_in;
      oor_ff <= oor_in;
   end

   always_comb begin
      logic [SP_W-1:0]    sp_dec;
      logic [SYM_W-1:0]   sym;
      logic [RULE_AW-1:0] idx;
      logic [RULE_AW-1:0] lidx;
      gpd_pkg::rule_pair_type pair;

      sp_dec    = sp_ff - SP_W'(1);
      sym       = stk_rd_data;
      idx       = ~sym[RULE_AW-1:0];
      pair      = oor_ff ? '0 : rule_rd_data;
      lidx      = ~pair.left_symbol[RULE_AW-1:0];

      state_in  = state_ff;
      sp_in     = sp_ff;
      res_in    = res_ff;
      oor_in    = oor_ff;
      rule_req  = '0;
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      stk_re    = 1'b0;
      stk_raddr = sp_dec[SA_W-1:0];
      req_ready = (state_ff == gpd_pkg::S_IDLE);
      res_valid = (state_ff == gpd_pkg::S_OUT);

      unique case (state_ff)
         gpd_pkg::S_IDLE: begin
            if (req_valid) begin
               res_in = '{status: gpd_pkg::ST_IDLE, out_byte: '0, run_done: 1'b0};
               case (req_item.func)
                  gpd_pkg::FN_LOAD: begin
                     if (32'(req_item.rule_slot) < 32'(MAX_RULES)) begin
                        rule_req.we    = 1'b1;
                        rule_req.waddr = req_item.rule_slot;
                        rule_req.wdata = '{left_symbol:  req_item.left_symbol,
                                           right_symbol: req_item.right_symbol};
                     end
                  end
                  gpd_pkg::FN_PUSH: begin
                     if (sp_ff == '0) begin
                        stk_we        = 1'b1;
                        stk_wdata     = req_item.compressed_symbol;
                        sp_in         = SP_W'(1);
                        res_in.status = gpd_pkg::ST_PUSH_OK;
                     end else begin
                        res_in.status = gpd_pkg::ST_BUSY;
                     end
                     state_in = gpd_pkg::S_OUT;
                  end
                  gpd_pkg::FN_TICK: begin
                     if (sp_ff == '0) begin
                        state_in = gpd_pkg::S_OUT;
                     end else begin
                        stk_re   = 1'b1;
                        sp_in    = sp_dec;
                        state_in = gpd_pkg::S_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         gpd_pkg::S_POP: begin
            if (!sym[SYM_W-1]) begin
               res_in   = '{status: gpd_pkg::ST_EMIT, out_byte: sym[7:0],
                            run_done: (sp_ff == '0)};
               state_in = gpd_pkg::S_OUT;
            end else begin
               rule_req.re    = 1'b1;
               rule_req.raddr = idx;
               oor_in         = !(32'(idx) < 32'(MAX_RULES));
               state_in       = gpd_pkg::S_RULE;
            end
         end
         gpd_pkg::S_RULE: begin
            // The right symbol goes to the stack; the left one is expanded at once.
            if (sp_ff > SP_OVF_LIM) begin
               sp_in    = '0;
               res_in   = '{status: gpd_pkg::ST_OVERFLOW, out_byte: '0, run_done: 1'b0};
               state_in = gpd_pkg::S_OUT;
            end else begin
               stk_we    = 1'b1;
               stk_waddr = sp_ff[SA_W-1:0];
               stk_wdata = pair.right_symbol;
               sp_in     = sp_ff + SP_W'(1);
               if (!pair.left_symbol[SYM_W-1]) begin
                  res_in   = '{status: gpd_pkg::ST_EMIT,
                               out_byte: pair.left_symbol[7:0], run_done: 1'b0};
                  state_in = gpd_pkg::S_OUT;
               end else begin
                  rule_req.re    = 1'b1;
                  rule_req.raddr = lidx;
                  oor_in = !(32'(lidx) < 32'(MAX_RULES));
               end
            end
         end
         gpd_pkg::S_OUT: begin
            if (out_free) begin
               state_in = gpd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gpd_pkg::S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

`ifndef SYNTH
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("Stack pointer beyond stack depth.");

   a_rule_write_idle: assert property (@(posedge clock) disable iff (reset)
      rule_req.we |-> (state_ff == gpd_pkg::S_IDLE) && req_valid)
      else $error("Rule write outside an accepted load request.");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gpd_pkg::S_OUT) && (res_ff.status == gpd_pkg::ST_EMIT)
         && res_ff.run_done |-> (sp_ff == '0))
      else $error("Run end reported with symbols left on the stack.");

   a_ovf_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gpd_pkg::S_OUT) && (res_ff.status == gpd_pkg::ST_OVERFLOW)
         |-> (sp_ff == '0))
      else $error("Overflow did not clear the stack.");
`endif

endmodule

// ===== rtl/core/grammar_pair_decompressor_core.sv =====
// Top level of the pair grammar decompressor with its result register.
//
//   Channel  Direction  Payload
//   req      in         tuser func; tdata rule_slot, left, right, compressed symbol
//   rsp      out        tuser status; tdata out_byte; tlast run_done
//
// A load writes the rule table, a push the stack; a tick pops it and reads one
// rule for every nested rule on the way to the next terminal: the walk does one
// rule-memory read per cycle. Reset empties the stack only; the rule table and
// the stack memory keep their contents and need no clearing pass. A finished
// result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module grammar_pair_decompressor_core #(
   parameter int MAX_RULES   = 1024,
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // rule_slot[9:0], left_symbol[20:10], right_symbol[31:21],
   // compressed_symbol[42:32], zero fill[47:43]
   input  logic [47:0] req_tdata,
   // func[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_byte[7:0]
   output logic [7:0]  rsp_tdata,
   // status[2:0]
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int RULE_DEPTH = (MAX_RULES < 1024) ? MAX_RULES : 1024;
   localparam int SA_W = $clog2(STACK_DEPTH);

   gpd_pkg::req_item_type   req_item;
   gpd_pkg::rule_req_type   rule_req;
   gpd_pkg::rule_pair_type  rule_rd_data;
   logic                    stk_we;
   logic [SA_W-1:0]         stk_waddr;
   logic [gpd_pkg::SYM_W-1:0] stk_wdata;
   logic                    stk_re;
   logic [SA_W-1:0]         stk_raddr;
   logic [gpd_pkg::SYM_W-1:0] stk_rd_data;
   logic                    res_valid;
   gpd_pkg::result_type     res;
   logic                    out_free;

   logic                    rsp_valid_ff, rsp_valid_in;
   gpd_pkg::result_type     rsp_data_ff, rsp_data_in;

   assign req_item.func              = gpd_pkg::func_type'(req_tuser);
   assign req_item.rule_slot         = req_tdata[9:0];
   assign req_item.left_symbol       = req_tdata[20:10];
   assign req_item.right_symbol      = req_tdata[31:21];
   assign req_item.compressed_symbol = req_tdata[42:32];

   gpd_rule_mem #(
      .DEPTH (RULE_DEPTH)
   ) u_rule_mem (
      .clock   (clock),
      .rule_req(rule_req),
      .rd_data (rule_rd_data)
   );

   gpd_stack_mem #(
      .DEPTH (STACK_DEPTH)
   ) u_stack_mem (
      .clock  (clock),
      .we     (stk_we),
      .waddr  (stk_waddr),
      .wdata  (stk_wdata),
      .re     (stk_re),
      .raddr  (stk_raddr),
      .rd_data(stk_rd_data)
   );

   gpd_ctrl #(
      .MAX_RULES  (MAX_RULES),
      .STACK_DEPTH(STACK_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_item    (req_item),
      .rule_req    (rule_req),
      .rule_rd_data(rule_rd_data),
      .stk_we      (stk_we),
      .stk_waddr   (stk_waddr),
      .stk_wdata   (stk_wdata),
      .stk_re      (stk_re),
      .stk_raddr   (stk_raddr),
      .stk_rd_data (stk_rd_data),
      .res_valid   (res_valid),
      .res         (res),
      .out_free    (out_free)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff.out_byte;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tlast  = rsp_data_ff.run_done;

endmodule

// ===== dv/tb_grammar_pair_decompressor_core.sv =====
// Self-checking testbench that drives grammar loads, pushes and ticks through the decompressor.
`timescale 1ns / 1ps

module tb_grammar_pair_decompressor_core;

   localparam int RULES        = 1024;
   localparam int DEPTH        = 64;
   localparam int ITEM_COUNT   = 900;
   localparam int LENGTH_CAP   = 48;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 100;
   localparam int SYM_W        = gpd_pkg::SYM_W;
   localparam int RULE_AW      = gpd_pkg::RULE_AW;
   localparam gpd_pkg::func_type FN_UNUSED = gpd_pkg::func_type'(2'd3);

   typedef logic signed [SYM_W-1:0] symbol_type;

   class expansion_scoreboard;
      symbol_type left_tab[RULES];
      symbol_type right_tab[RULES];
      symbol_type stack_mem[DEPTH];
      int depth;
      int errors;
      gpd_pkg::result_type pending_responses[$];

      function new();
         depth = 0;
         errors = 0;
      endfunction

      function void note_request(gpd_pkg::req_item_type req);
         gpd_pkg::result_type res;
         int sym;
         int idx;
         res.status = gpd_pkg::ST_IDLE;
         res.out_byte = '0;
         res.run_done = 1'b0;
         case (req.func)
            gpd_pkg::FN_LOAD: begin
               left_tab[req.rule_slot] = req.left_symbol;
               right_tab[req.rule_slot] = req.right_symbol;
               return;
            end
            gpd_pkg::FN_PUSH: begin
               if (depth == 0) begin
                  stack_mem[0] = req.compressed_symbol;
                  depth = 1;
                  res.status = gpd_pkg::ST_PUSH_OK;
               end else begin
                  res.status = gpd_pkg::ST_BUSY;
               end
            end
            gpd_pkg::FN_TICK: begin
               // Rules are replaced right then left, so the left side is walked first.
               while (depth > 0) begin
                  depth--;
                  sym = stack_mem[depth];
                  if (sym >= 0) begin
                     res.status = gpd_pkg::ST_EMIT;
                     res.out_byte = sym[7:0];
                     res.run_done = (depth == 0);
                     break;
                  end
                  idx = -sym - 1;
                  if (depth + 2 > DEPTH) begin
                     depth = 0;
                     res.status = gpd_pkg::ST_OVERFLOW;
                     break;
                  end
                  stack_mem[depth] = right_tab[idx];
                  stack_mem[depth + 1] = left_tab[idx];
                  depth += 2;
               end
            end
            default: return;
         endcase
         pending_responses.push_back(res);
      endfunction

      // Number of ticks a pushed symbol needs before the stack is empty again.
      function int run_length(int sym);
         int st[DEPTH];
         int n;
         int ticks;
         int s;
         int idx;
         st[0] = sym;
         n = 1;
         ticks = 0;
         while (n > 0 && ticks <= LENGTH_CAP) begin
            n--;
            s = st[n];
            if (s >= 0) begin
               ticks++;
            end else begin
               idx = -s - 1;
               if (n + 2 > DEPTH) begin
                  ticks++;
                  n = 0;
               end else begin
                  st[n] = right_tab[idx];
                  st[n + 1] = left_tab[idx];
                  n += 2;
               end
            end
         end
         return ticks;
      endfunction

      function void check_result(gpd_pkg::status_type status, logic [7:0] out_byte,
                                 logic run_done);
         gpd_pkg::result_type want;
         if (pending_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected response status=%0d byte=%0h done=%0b",
                     $time, status, out_byte, run_done);
            return;
         end
         want = pending_responses.pop_front();
         if (status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
         end
         if (out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %0h actual %0h", $time, want.out_byte, out_byte);
         end
         if (run_done !== want.run_done) begin
            errors++;
            $display("%0t: run_done expected %0b actual %0b", $time, want.run_done, run_done);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int tx_idle_pct = 17;
   int rx_idle_pct = 76;
   bit hold_rsp = 1'b0;
   int requests_sent = 0;
   int cycle_count = 0;
   bit slot_written[RULES];
   int written_q[$];
   expansion_scoreboard sb = new();

   grammar_pair_decompressor_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic gpd_pkg::req_item_type make_item(gpd_pkg::func_type f, int slot, int l,
                                                       int r, int c);
      gpd_pkg::req_item_type req;
      req.func = f;
      req.rule_slot = RULE_AW'(slot);
      req.left_symbol = SYM_W'(l);
      req.right_symbol = SYM_W'(r);
      req.compressed_symbol = SYM_W'(c);
      return req;
   endfunction

   // Rules only name lower slots, so the only cycles are left self-references.
   function automatic int pick_symbol(int below, int max_len);
      int slot;
      for (int i = 0; i < 6; i++) begin
         if (written_q.size() == 0) break;
         slot = written_q[$urandom_range(written_q.size() - 1)];
         if (slot < below && sb.run_length(-slot - 1) <= max_len) return -slot - 1;
      end
      return $urandom_range(1023);
   endfunction

   function automatic gpd_pkg::req_item_type random_request();
      int roll;
      int slot;
      int l;
      roll = $urandom_range(99);
      if (sb.depth > 0) begin
         if (roll < 85)
            return make_item(gpd_pkg::FN_TICK, $urandom_range(1023), $urandom_range(2047),
                             $urandom_range(2047), $urandom_range(2047));
         if (roll < 90)
            return make_item(gpd_pkg::FN_PUSH, $urandom_range(1023), $urandom_range(2047),
                             $urandom_range(2047), $urandom_range(2047));
         if (roll < 97)
            return make_item(gpd_pkg::FN_LOAD, $urandom_range(1023), $urandom_range(1023),
                             $urandom_range(1023), $urandom_range(2047));
         return make_item(FN_UNUSED, $urandom_range(1023), $urandom_range(2047),
                          $urandom_range(2047), $urandom_range(2047));
      end
      if (roll < 10)
         return make_item(gpd_pkg::FN_PUSH, $urandom_range(1023), $urandom_range(2047),
                          $urandom_range(2047), $urandom_range(1023));
      if (roll < 45)
         return make_item(gpd_pkg::FN_PUSH, $urandom_range(1023), $urandom_range(2047),
                          $urandom_range(2047), pick_symbol(RULES, 40));
      if (roll < 75) begin
         slot = $urandom_range(1023);
         l = ($urandom_range(19) == 0) ? -slot - 1 : pick_symbol(slot, 12);
         return make_item(gpd_pkg::FN_LOAD, slot, l, pick_symbol(slot, 12),
                          $urandom_range(2047));
      end
      if (roll < 92)
         return make_item(gpd_pkg::FN_TICK, $urandom_range(1023), $urandom_range(2047),
                          $urandom_range(2047), $urandom_range(2047));
      return make_item(FN_UNUSED, $urandom_range(1023), $urandom_range(2047),
                       $urandom_range(2047), $urandom_range(2047));
   endfunction

   task automatic send_request(gpd_pkg::req_item_type req);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= req.func;
      req_tdata <= {5'b0, req.compressed_symbol, req.right_symbol, req.left_symbol,
                    req.rule_slot};
      do @(posedge clock); while (!req_tready);
      sb.note_request(req);
      if (req.func == gpd_pkg::FN_LOAD && !slot_written[req.rule_slot]) begin
         slot_written[req.rule_slot] = 1'b1;
         written_q.push_back(req.rule_slot);
      end
      if (req.func != FN_UNUSED) requests_sent++;
   endtask

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         sb.check_result(gpd_pkg::status_type'(rsp_tuser), rsp_tdata, rsp_tlast);
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("grammar_pair_decompressor_core: mismatch");
         $finish;
      end
   end

   // The receiver stops for a long stretch while requests keep coming.
   initial begin
      wait (requests_sent >= 3 * ITEM_COUNT / 4);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_item(gpd_pkg::FN_TICK, 0, 0, 0, 0));
      send_request(make_item(gpd_pkg::FN_LOAD, 0, 0, 255, 0));
      send_request(make_item(gpd_pkg::FN_LOAD, 1, -1, 1023, 0));
      send_request(make_item(gpd_pkg::FN_LOAD, 1023, -1024, 7, 0));
      send_request(make_item(gpd_pkg::FN_LOAD, 1022, 3, -1024, 0));
      send_request(make_item(gpd_pkg::FN_PUSH, 0, 0, 0, 0));
      send_request(make_item(gpd_pkg::FN_PUSH, 0, 0, 0, 5));
      repeat (2) send_request(make_item(gpd_pkg::FN_TICK, 0, 0, 0, 0));
      send_request(make_item(gpd_pkg::FN_PUSH, 0, 0, 0, -2));
      repeat (4) send_request(make_item(gpd_pkg::FN_TICK, 0, 0, 0, 0));
      send_request(make_item(gpd_pkg::FN_PUSH, 0, 0, 0, 1023));
      send_request(make_item(gpd_pkg::FN_TICK, 0, 0, 0, 0));
      send_request(make_item(gpd_pkg::FN_PUSH, 0, 0, 0, -1024));
      repeat (2) send_request(make_item(gpd_pkg::FN_TICK, 0, 0, 0, 0));
      send_request(make_item(gpd_pkg::FN_PUSH, 0, 0, 0, -1023));
      repeat (2) send_request(make_item(gpd_pkg::FN_TICK, 0, 0, 0, 0));
      send_request(make_item(FN_UNUSED, 1023, -1, -1, -1));

      while (requests_sent < ITEM_COUNT) begin
         if (requests_sent >= 2 * ITEM_COUNT / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else if (requests_sent >= ITEM_COUNT / 3) begin
            tx_idle_pct = 76;
            rx_idle_pct = 17;
         end
         send_request(random_request());
      end
      req_tvalid <= 1'b0;

      while (sb.pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("grammar_pair_decompressor_core: match");
      else
         $display("grammar_pair_decompressor_core: mismatch");
      $finish;
   end

endmodule

// ===== grammar_pair_decompressor_core.f =====
rtl/core/gpd_pkg.sv
rtl/core/gpd_rule_mem.sv
rtl/core/gpd_stack_mem.sv
rtl/core/gpd_ctrl.sv
rtl/core/grammar_pair_decompressor_core.sv
dv/tb_grammar_pair_decompressor_core.sv
